@@ hdl/falu_pkg.sv @@
// ----------------------------------------------------------------------------
// falu_pkg: shared definitions for the Q24.8 fixed-point ALU
// Operation codes, status codes, channel payload types and saturation helper.
// ----------------------------------------------------------------------------
package falu_pkg;

  localparam int FRAC_BITS = 8;
  // Quotient bits produced by the divider chain: 32 integer plus FRAC_BITS.
  localparam int NB        = 32 + FRAC_BITS;

  localparam logic signed [31:0] MAX_RAW = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_RAW = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               flag;
    logic [1:0]         status;
  } out_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] sres;   // result of the single-cycle operations
    logic               sflag;
    logic [1:0]         sstat;
    logic signed [63:0] prod;   // full product for multiply
    logic               dz;     // divisor is zero
    logic               neg;    // quotient sign
    logic [31:0]        mb;     // divisor magnitude
    logic [31:0]        rem;    // partial remainder
    logic [NB-1:0]      nq;     // dividend bits shifting out, quotient bits in
  } cell_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic [1:0]         stat;
  } sat_t;

  // Applies a sign to a magnitude and clamps to the signed 32-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t s;
    s.stat = ST_OK;
    if (!neg && mag > 64'h0000_0000_7FFF_FFFF) begin
      s.res  = MAX_RAW;
      s.stat = ST_SAT;
    end else if (neg && mag > 64'h0000_0000_8000_0000) begin
      s.res  = MIN_RAW;
      s.stat = ST_SAT;
    end else if (neg) begin
      s.res = 32'(~mag[31:0] + 32'd1);
    end else begin
      s.res = mag[31:0];
    end
    return s;
  endfunction

endpackage

@@ hdl/falu_front.sv @@
// ----------------------------------------------------------------------------
// falu_front: operand decode
// Computes single-cycle operations, the product and the divider start values.
// ----------------------------------------------------------------------------
module falu_front import falu_pkg::*; (
  input  in_t   in_data,
  output cell_t stage
);

  logic signed [31:0] a, b;
  logic signed [32:0] sum, dif, inc, dec;
  logic signed [63:0] shl;
  logic [31:0]        ma;

  assign a = in_data.operand_a;
  assign b = in_data.operand_b;

  assign sum = {a[31], a} + {b[31], b};
  assign dif = {a[31], a} - {b[31], b};
  assign inc = {a[31], a} + 33'sd1;
  assign dec = {a[31], a} - 33'sd1;
  assign shl = 64'(a) <<< FRAC_BITS;
  assign ma  = a[31] ? 32'(-a) : a;

  function automatic sat_t sat33(input logic signed [32:0] v);
    sat_t s;
    s.stat = ST_OK;
    s.res  = v[31:0];
    if (v[32] != v[31]) begin
      s.res  = v[32] ? MIN_RAW : MAX_RAW;
      s.stat = ST_SAT;
    end
    return s;
  endfunction

  always_comb begin
    sat_t s;
    s           = '{res: '0, stat: ST_OK};
    stage.sflag = 1'b0;
    case (in_data.operation)
      OP_ADD:   s = sat33(sum);
      OP_SUB:   s = sat33(dif);
      OP_INC:   s = sat33(inc);
      OP_DEC:   s = sat33(dec);
      OP_DIV: begin
        if (b == 32'sd0) begin
          s.res  = a[31] ? MIN_RAW : MAX_RAW;
          s.stat = ST_DZ;
        end
      end
      OP_GT:    stage.sflag = a > b;
      OP_LT:    stage.sflag = a < b;
      OP_GE:    stage.sflag = a >= b;
      OP_LE:    stage.sflag = a <= b;
      OP_EQ:    stage.sflag = a == b;
      OP_NE:    stage.sflag = a != b;
      OP_MIN:   s.res = (a < b) ? a : b;
      OP_MAX:   s.res = (a > b) ? a : b;
      OP_TO_INT: s.res = a >>> FRAC_BITS;
      OP_FROM_INT: begin
        if (shl > 64'(MAX_RAW)) begin
          s.res  = MAX_RAW;
          s.stat = ST_SAT;
        end else if (shl < 64'(MIN_RAW)) begin
          s.res  = MIN_RAW;
          s.stat = ST_SAT;
        end else begin
          s.res = shl[31:0];
        end
      end
      default: s = '{res: '0, stat: ST_OK};
    endcase
    stage.op    = op_t'(in_data.operation);
    stage.sres  = s.res;
    stage.sstat = s.stat;
    stage.prod  = a * b;
    stage.dz    = (b == 32'sd0);
    stage.neg   = a[31] ^ b[31];
    stage.mb    = b[31] ? 32'(-b) : b;
    stage.rem   = '0;
    stage.nq    = {ma, {FRAC_BITS{1'b0}}};
  end

endmodule

@@ hdl/falu_cell.sv @@
// ----------------------------------------------------------------------------
// falu_cell: one restoring division step
// Shifts one dividend bit into the remainder and one quotient bit out.
// ----------------------------------------------------------------------------
module falu_cell import falu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_v,
  input  cell_t in_c,
  output logic  out_v,
  output cell_t out_c
);

  logic        v_r;
  cell_t       c_r, c_nxt;
  logic [32:0] t, diff;
  logic        ge;

  assign t    = {in_c.rem, in_c.nq[NB-1]};
  assign diff = t - {1'b0, in_c.mb};
  assign ge   = (t >= {1'b0, in_c.mb});

  always_comb begin
    c_nxt     = in_c;
    c_nxt.rem = ge ? diff[31:0] : t[31:0];
    c_nxt.nq  = {in_c.nq[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign out_v = v_r;
  assign out_c = c_r;

endmodule

@@ hdl/falu_back.sv @@
// ----------------------------------------------------------------------------
// falu_back: result finishing
// Rounds the product and the quotient, saturates and selects the result.
// ----------------------------------------------------------------------------
module falu_back import falu_pkg::*; (
  input  cell_t stage,
  output out_t  out_data
);

  logic [63:0] pm, pq, dq;
  logic        rnd;

  assign pm  = stage.prod[63] ? 64'(-stage.prod) : 64'(stage.prod);
  assign pq  = (pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rnd = ({stage.rem, 1'b0} >= {1'b0, stage.mb});
  assign dq  = 64'(stage.nq) + 64'(rnd);

  always_comb begin
    sat_t s;
    s = '{res: stage.sres, stat: stage.sstat};
    if (stage.op == OP_MUL) begin
      s = sat_mag(stage.prod[63], pq);
    end else if (stage.op == OP_DIV && !stage.dz) begin
      s = sat_mag(stage.neg, dq);
    end
    out_data.result = s.res;
    out_data.flag   = stage.sflag;
    out_data.status = s.stat;
  end

endmodule

@@ hdl/fixed_point_alu_q24_8_top.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_top: pipelined signed Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max and integer conversion.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload  Handshake
//  in_      input      in_t     in_valid / in_stall
//  out_     output     out_t    out_valid / out_stall
//
// One transaction is accepted per cycle unless the input is stalled. Every
// transaction, whatever its operation, runs through the same chain of
// NB = 32 + FRAC_BITS division cells and then the output register, so
// results leave in order. The divider chain sets the latency; the front
// multiplier and the single-cycle operations ride along with the
// transaction.
// Reset (synchronous, active low) clears the valid bits of the chain and
// the output register. A stalled output freezes the whole chain; the head
// cell still takes a transaction while it is empty.
//
module fixed_point_alu_q24_8_top import falu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Output register: the chain's last stage.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  // Front end: single-cycle results, product and divider start values.
  cell_t front_c;

  falu_front u_front (
    .in_data (in_data),
    .stage   (front_c)
  );

  // The chain holds as a whole while the output transaction is refused.
  logic hold;
  assign hold     = out_valid_r & out_stall;

  logic  v  [NB+1];
  cell_t c  [NB+1];
  logic  en [NB];

  assign v[0] = in_valid;
  assign c[0] = front_c;

  // Only the head cell may fill while the chain holds, and only when empty.
  assign in_stall = hold & v[1];

  genvar gi;
  generate
    for (gi = 0; gi < NB; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign en[gi] = !hold || !v[1];
      end else begin : g_body
        assign en[gi] = !hold;
      end
      falu_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en[gi]),
        .in_v  (v[gi]),
        .in_c  (c[gi]),
        .out_v (v[gi+1]),
        .out_c (c[gi+1])
      );
    end
  endgenerate

  // Rounding, saturation and result selection after the last cell.
  out_t back_d;

  falu_back u_back (
    .stage    (c[NB]),
    .out_data (back_d)
  );

  assign out_valid_nxt = hold ? out_valid_r : v[NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_data_r <= back_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A true comparison carries a zero result and an ok status.
  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flag |-> out_data.result == 32'sd0 && out_data.status == ST_OK)
    else $error("comparison flag with nonzero result or status");

  // Division by zero always lands on one of the two bounds.
  a_dz_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DZ |->
      out_data.result == MAX_RAW || out_data.result == MIN_RAW)
    else $error("division by zero result not at a bound");

  // Status code three is never produced.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  // The input side is only stalled while the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
`endif

endmodule
